/* src/pfd_pkg.sv */
package pfd_pkg;

	localparam int POS_BITS = 10;
	localparam int GAIN_W   = 8;
	localparam int MARGIN_W = 8;
	localparam int MAG_W    = 8;
	localparam int ERR_W    = POS_BITS + 1;
	localparam int CMP_W    = POS_BITS + 2;
	localparam int DIFF_W   = POS_BITS + 2;
	localparam int TERM_W   = POS_BITS + 12;
	localparam int CFG_W    = (POS_BITS > GAIN_W) ? POS_BITS : GAIN_W;
	localparam int IDX_W    = 3;

	localparam int RADIUS_CUTOFF = 5;
	localparam int OUT_DEADZONE  = 150;
	localparam int SAT_MAX       = 255;

	localparam int X_TARGET_RST      = 80;
	localparam int X_MARGIN_RST      = 5;
	localparam int RADIUS_TARGET_RST = 30;
	localparam int RADIUS_MARGIN_RST = 0;
	localparam int TURN_P_GAIN_RST   = 7;
	localparam int TURN_D_GAIN_RST   = 2;
	localparam int MOVE_P_GAIN_RST   = 20;
	localparam int MOVE_D_GAIN_RST   = 5;

	typedef enum logic [IDX_W-1:0] {
		REG_X_TARGET      = 3'd0,
		REG_X_MARGIN      = 3'd1,
		REG_RADIUS_TARGET = 3'd2,
		REG_RADIUS_MARGIN = 3'd3,
		REG_TURN_P_GAIN   = 3'd4,
		REG_TURN_D_GAIN   = 3'd5,
		REG_MOVE_P_GAIN   = 3'd6,
		REG_MOVE_D_GAIN   = 3'd7
	} reg_index_t;

	// outcome of one pd term after the output dead zone and saturation
	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [MAG_W-1:0] mag;
	} term_t;

endpackage

/* src/pfd_pd_term.sv */
module pfd_pd_term (
	input  logic [pfd_pkg::POS_BITS-1:0]      value,
	input  logic [pfd_pkg::POS_BITS-1:0]      target,
	input  logic [pfd_pkg::MARGIN_W-1:0]      margin,
	input  logic [pfd_pkg::GAIN_W-1:0]        p_gain,
	input  logic [pfd_pkg::GAIN_W-1:0]        d_gain,
	input  logic signed [pfd_pkg::ERR_W-1:0]  last_err,
	output logic signed [pfd_pkg::ERR_W-1:0]  err,
	output pfd_pkg::term_t                    term
);

	localparam int CW = pfd_pkg::CMP_W;
	localparam int EW = pfd_pkg::ERR_W;
	localparam int DW = pfd_pkg::DIFF_W;
	localparam int TW = pfd_pkg::TERM_W;
	localparam int GW = pfd_pkg::GAIN_W;
	localparam int PP_W = GW + 1 + EW;
	localparam int PD_W = GW + 1 + DW;
	localparam int MAG_W_L = pfd_pkg::MAG_W;

	logic signed [CW-1:0]   v_s, t_s, m_s, lo, hi, raw;
	logic                   in_zone;
	logic signed [DW-1:0]   diff;
	logic signed [GW:0]     gp, gd;
	logic signed [PP_W-1:0] prod_p;
	logic signed [PD_W-1:0] prod_d;
	logic signed [TW-1:0]   sum, mag_full;
	logic                   small_term;
	logic [MAG_W_L-1:0]     sat;

	always_comb begin
		v_s = $signed({2'b00, value});
		t_s = $signed({2'b00, target});
		m_s = $signed({{(CW - pfd_pkg::MARGIN_W){1'b0}}, margin});
		lo  = t_s - m_s;
		hi  = t_s + m_s;
		raw = v_s - t_s;
		// dead zone is open on both ends, so a zero margin never applies
		in_zone = (v_s > lo) && (v_s < hi);
		err = in_zone ? '0 : raw[EW-1:0];

		diff = {err[EW-1], err} - {last_err[EW-1], last_err};
		gp = $signed({1'b0, p_gain});
		gd = $signed({1'b0, d_gain});
		prod_p = gp * err;
		prod_d = gd * diff;
		sum = {{(TW - PP_W){prod_p[PP_W-1]}}, prod_p}
			+ {{(TW - PD_W){prod_d[PD_W-1]}}, prod_d};

		small_term = (sum > -$signed(TW'(pfd_pkg::OUT_DEADZONE)))
			&& (sum < $signed(TW'(pfd_pkg::OUT_DEADZONE)));
		mag_full = sum[TW-1] ? -sum : sum;
		sat = (mag_full > $signed(TW'(pfd_pkg::SAT_MAX)))
			? MAG_W_L'(pfd_pkg::SAT_MAX) : mag_full[MAG_W_L-1:0];

		term.zero = small_term;
		term.neg  = !small_term && sum[TW-1];
		term.mag  = small_term ? '0 : sat;
	end

endmodule

/* src/pd_target_follow_drive.sv */
// Follows a tracked object with two PD controllers, one for steering from the
// horizontal position and one for driving from the apparent radius. One item
// is accepted per clock cycle while in_ready is high; each accepted item with a
// radius above the minimum yields one result (input register, then one pass
// through both PD terms into the result register), while items with a small
// radius give no result and leave the stored errors alone. A result waiting in
// the output register still lets an empty input register take one more item,
// which then holds until the result is taken; an item with a small radius never
// waits. Configuration is written through cfg_we/cfg_index/cfg_data and takes
// effect from the next item; write it only while the block is idle.
module pd_target_follow_drive (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pfd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pfd_pkg::POS_BITS-1:0]  x_position,
	input  logic [pfd_pkg::POS_BITS-1:0]  radius,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          drive_backward,
	output logic [pfd_pkg::MAG_W-1:0]     speed,
	output logic                          turn_left,
	output logic [pfd_pkg::MAG_W-1:0]     turn_amount
);

	localparam int PB = pfd_pkg::POS_BITS;
	localparam int GW = pfd_pkg::GAIN_W;
	localparam int MW = pfd_pkg::MARGIN_W;
	localparam int EW = pfd_pkg::ERR_W;

	logic [PB-1:0] x_target_q, radius_target_q;
	logic [MW-1:0] x_margin_q, radius_margin_q;
	logic [GW-1:0] turn_p_gain_q, turn_d_gain_q, move_p_gain_q, move_d_gain_q;

	logic          valid_s1;
	logic [PB-1:0] x_s1, radius_s1;

	logic signed [EW-1:0] last_x_err_q, last_r_err_q;
	logic signed [EW-1:0] x_err, r_err;
	pfd_pkg::term_t       turn_t, move_t;

	logic          out_valid_q;
	logic          back_q, left_q;
	logic [pfd_pkg::MAG_W-1:0] speed_q, tamt_q;

	logic produce, out_free, s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_target_q      <= PB'(pfd_pkg::X_TARGET_RST);
			x_margin_q      <= MW'(pfd_pkg::X_MARGIN_RST);
			radius_target_q <= PB'(pfd_pkg::RADIUS_TARGET_RST);
			radius_margin_q <= MW'(pfd_pkg::RADIUS_MARGIN_RST);
			turn_p_gain_q   <= GW'(pfd_pkg::TURN_P_GAIN_RST);
			turn_d_gain_q   <= GW'(pfd_pkg::TURN_D_GAIN_RST);
			move_p_gain_q   <= GW'(pfd_pkg::MOVE_P_GAIN_RST);
			move_d_gain_q   <= GW'(pfd_pkg::MOVE_D_GAIN_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfd_pkg::REG_X_TARGET:      x_target_q      <= cfg_data[PB-1:0];
				pfd_pkg::REG_X_MARGIN:      x_margin_q      <= cfg_data[MW-1:0];
				pfd_pkg::REG_RADIUS_TARGET: radius_target_q <= cfg_data[PB-1:0];
				pfd_pkg::REG_RADIUS_MARGIN: radius_margin_q <= cfg_data[MW-1:0];
				pfd_pkg::REG_TURN_P_GAIN:   turn_p_gain_q   <= cfg_data[GW-1:0];
				pfd_pkg::REG_TURN_D_GAIN:   turn_d_gain_q   <= cfg_data[GW-1:0];
				pfd_pkg::REG_MOVE_P_GAIN:   move_p_gain_q   <= cfg_data[GW-1:0];
				pfd_pkg::REG_MOVE_D_GAIN:   move_d_gain_q   <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	pfd_pd_term u_turn (
		.value    (x_s1),
		.target   (x_target_q),
		.margin   (x_margin_q),
		.p_gain   (turn_p_gain_q),
		.d_gain   (turn_d_gain_q),
		.last_err (last_x_err_q),
		.err      (x_err),
		.term     (turn_t)
	);

	pfd_pd_term u_move (
		.value    (radius_s1),
		.target   (radius_target_q),
		.margin   (radius_margin_q),
		.p_gain   (move_p_gain_q),
		.d_gain   (move_d_gain_q),
		.last_err (last_r_err_q),
		.err      (r_err),
		.term     (move_t)
	);

	always_comb begin
		produce  = radius_s1 > PB'(pfd_pkg::RADIUS_CUTOFF);
		out_free = !out_valid_q || out_ready;
		// an item with a small radius leaves the input register at once
		s1_move  = valid_s1 && (out_free || !produce);
		in_ready = !valid_s1 || s1_move;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1      <= x_position;
			radius_s1 <= radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_err_q <= '0;
			last_r_err_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_move && produce) begin
				last_x_err_q <= x_err;
				last_r_err_q <= r_err;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && produce) begin
			back_q  <= !move_t.neg;
			speed_q <= move_t.mag;
			// zero speed forces the turn to zero
			left_q  <= turn_t.neg && !move_t.zero;
			tamt_q  <= move_t.zero ? '0 : turn_t.mag;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_backward = back_q;
	assign speed          = speed_q;
	assign turn_left      = left_q;
	assign turn_amount    = tamt_q;

	a_zero_speed_no_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (speed_q == '0) |-> (tamt_q == '0) && !left_q && back_q)
		else $error("turn not cleared at zero speed");

	a_speed_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (speed_q != '0)
			|-> (speed_q >= pfd_pkg::MAG_W'(pfd_pkg::OUT_DEADZONE)))
		else $error("speed inside output dead zone");

	a_small_radius_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !produce |=> $stable(last_x_err_q) && $stable(last_r_err_q))
		else $error("stored error changed on small radius item");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("waiting result lost");

endmodule

/* tb/pd_follow_checker.sv */
module pd_follow_checker
	import pfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [POS_BITS-1:0] x_position,
	input  logic [POS_BITS-1:0] radius,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                drive_backward,
	input  logic [MAG_W-1:0]    speed,
	input  logic                turn_left,
	input  logic [MAG_W-1:0]    turn_amount,
	output int                  outstanding,
	output int                  mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             backward;
		logic [MAG_W-1:0] spd;
		logic             left;
		logic [MAG_W-1:0] amount;
	} drive_cmd_t;

	int x_tgt, x_marg, r_tgt, r_marg;
	int turn_kp, turn_kd, move_kp, move_kd;
	logic signed [ERR_W-1:0] prev_x_err, prev_r_err;
	drive_cmd_t cmd_q[$];

	function automatic int dead_zone_err(int v, int tgt, int marg);
		if (v > tgt - marg && v < tgt + marg)
			return 0;
		return v - tgt;
	endfunction

	function automatic int sat_mag(int v);
		int m;
		m = (v < 0) ? -v : v;
		return (m > SAT_MAX) ? SAT_MAX : m;
	endfunction

	// computes the drive command for one frame and updates the stored errors
	function automatic drive_cmd_t follow_step(int xp, int rp);
		int ex, er, turn, move;
		drive_cmd_t cmd;
		er = dead_zone_err(rp, r_tgt, r_marg);
		ex = dead_zone_err(xp, x_tgt, x_marg);
		turn = turn_kp * ex + turn_kd * (ex - int'(prev_x_err));
		move = move_kp * er + move_kd * (er - int'(prev_r_err));
		if (turn > -OUT_DEADZONE && turn < OUT_DEADZONE)
			turn = 0;
		if (move > -OUT_DEADZONE && move < OUT_DEADZONE)
			move = 0;
		cmd.backward = (move >= 0);
		cmd.spd = MAG_W'(sat_mag(move));
		// no turning while standing still
		if (cmd.spd == 0)
			turn = 0;
		cmd.left = (turn < 0);
		cmd.amount = MAG_W'(sat_mag(turn));
		prev_x_err = ex[ERR_W-1:0];
		prev_r_err = er[ERR_W-1:0];
		return cmd;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		drive_cmd_t got, want;
		if (!arst_n) begin
			x_tgt = X_TARGET_RST;
			x_marg = X_MARGIN_RST;
			r_tgt = RADIUS_TARGET_RST;
			r_marg = RADIUS_MARGIN_RST;
			turn_kp = TURN_P_GAIN_RST;
			turn_kd = TURN_D_GAIN_RST;
			move_kp = MOVE_P_GAIN_RST;
			move_kd = MOVE_D_GAIN_RST;
			prev_x_err = '0;
			prev_r_err = '0;
			cmd_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready && radius > RADIUS_CUTOFF)
				cmd_q.push_back(follow_step(int'(x_position), int'(radius)));
			if (out_valid && out_ready) begin
				got = '{drive_backward, speed, turn_left, turn_amount};
				if (cmd_q.size() == 0) begin
					$error("result with no item pending: backward %0d speed %0d left %0d turn %0d",
						got.backward, got.spd, got.left, got.amount);
					mismatches++;
				end else begin
					want = cmd_q.pop_front();
					if (got.backward !== want.backward) begin
						$error("drive_backward: expected %0d, got %0d", want.backward, got.backward);
						mismatches++;
					end
					if (got.spd !== want.spd) begin
						$error("speed: expected %0d, got %0d", want.spd, got.spd);
						mismatches++;
					end
					if (got.left !== want.left) begin
						$error("turn_left: expected %0d, got %0d", want.left, got.left);
						mismatches++;
					end
					if (got.amount !== want.amount) begin
						$error("turn_amount: expected %0d, got %0d", want.amount, got.amount);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_X_TARGET:      x_tgt = int'(cfg_data[POS_BITS-1:0]);
					REG_X_MARGIN:      x_marg = int'(cfg_data[MARGIN_W-1:0]);
					REG_RADIUS_TARGET: r_tgt = int'(cfg_data[POS_BITS-1:0]);
					REG_RADIUS_MARGIN: r_marg = int'(cfg_data[MARGIN_W-1:0]);
					REG_TURN_P_GAIN:   turn_kp = int'(cfg_data[GAIN_W-1:0]);
					REG_TURN_D_GAIN:   turn_kd = int'(cfg_data[GAIN_W-1:0]);
					REG_MOVE_P_GAIN:   move_kp = int'(cfg_data[GAIN_W-1:0]);
					REG_MOVE_D_GAIN:   move_kd = int'(cfg_data[GAIN_W-1:0]);
					default: ;
				endcase
			end
			outstanding <= cmd_q.size();
		end
	end

endmodule

/* tb/tb_pd_target_follow_drive.sv */
module tb_pd_target_follow_drive;
	timeunit 1ns;
	timeprecision 1ps;

	import pfd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 290;
	localparam int POS_MAX         = (1 << POS_BITS) - 1;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [POS_BITS-1:0] x_position;
	logic [POS_BITS-1:0] radius;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                drive_backward;
	logic [MAG_W-1:0]    speed;
	logic                turn_left;
	logic [MAG_W-1:0]    turn_amount;

	int outstanding;
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	int cur_x_tgt;
	int cur_r_tgt;

	pd_target_follow_drive DUT (.*);

	pd_follow_checker drive_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic logic [POS_BITS-1:0] clamp_pos(int v);
		if (v < 0)
			return '0;
		if (v > POS_MAX)
			return '1;
		return v[POS_BITS-1:0];
	endfunction

	task automatic send_frame(logic [POS_BITS-1:0] xp, logic [POS_BITS-1:0] rp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			x_position <= POS_BITS'($urandom);
			radius <= POS_BITS'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_position <= xp;
		radius <= rp;
		do @(posedge clk); while (!in_ready);
	endtask

	// holds off the sender until every pending result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
	endtask

	task automatic program_regs(int xt, int xm, int rt, int rm, int tp, int td, int mp, int md);
		drain_results();
		write_reg(REG_X_TARGET, xt);
		write_reg(REG_X_MARGIN, xm);
		write_reg(REG_RADIUS_TARGET, rt);
		write_reg(REG_RADIUS_MARGIN, rm);
		write_reg(REG_TURN_P_GAIN, tp);
		write_reg(REG_TURN_D_GAIN, td);
		write_reg(REG_MOVE_P_GAIN, mp);
		write_reg(REG_MOVE_D_GAIN, md);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_x_tgt = xt & POS_MAX;
		cur_r_tgt = rt & POS_MAX;
	endtask

	// mostly frames near the targets so the dead zones and pd terms get exercised
	task automatic send_random_frame();
		int kind;
		logic [POS_BITS-1:0] xp, rp;
		kind = $urandom_range(99);
		if (kind < 10) begin
			xp = POS_BITS'($urandom);
			rp = POS_BITS'($urandom_range(RADIUS_CUTOFF));
		end else if (kind < 35) begin
			xp = POS_BITS'($urandom);
			rp = POS_BITS'($urandom);
		end else begin
			xp = clamp_pos(cur_x_tgt + int'($urandom_range(120)) - 60);
			rp = clamp_pos(cur_r_tgt + int'($urandom_range(40)) - 20);
		end
		send_frame(xp, rp);
	endtask

	function automatic int rand_gain();
		return ($urandom_range(1) != 0) ? int'($urandom_range(255)) : int'($urandom_range(12));
	endfunction

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[pd_target_follow_drive] ERROR");
		$finish;
	end

	initial begin : stimulus
		int dir_x[] = '{0, 1023, 80, 75, 76, 85, 84, 1023, 0, 1023, 0, 80, 80, 90, 70,
			512, 81, 79, 300, 20};
		int dir_r[] = '{0, 5, 6, 30, 30, 31, 37, 1023, 1023, 6, 6, 30, 30, 38, 22,
			200, 40, 12, 4, 29};
		int n;

		in_valid <= 1'b0;
		x_position <= '0;
		radius <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_X_TARGET;
		cfg_data <= '0;
		send_idle_pct = 17;
		recv_idle_pct = 48;
		cur_x_tgt = X_TARGET_RST;
		cur_r_tgt = RADIUS_TARGET_RST;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// power-on settings: dead zone edges, small radius, zero speed, saturation
		foreach (dir_x[i])
			send_frame(POS_BITS'(dir_x[i]), POS_BITS'(dir_r[i]));
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 48;
				recv_idle_pct = 17;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: program_regs(POS_MAX, 255, POS_MAX, 255, 255, 255, 255, 255);
				1: program_regs(0, 0, 0, 0, 0, 255, 0, 255);
				2: program_regs(512, 0, 100, 3, 1, 0, 2, 0);
				default: program_regs($urandom_range(POS_MAX), $urandom_range(POS_MAX),
					$urandom_range(RADIUS_CUTOFF + 1, 200), $urandom_range(12),
					rand_gain(), rand_gain(), rand_gain(), rand_gain());
			endcase
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				send_random_frame();
				n++;
				if (n == ITEMS_PER_PHASE / 2)
					drain_results();
			end
		end

		drain_results();
		@(negedge clk);
		if (mismatches == 0)
			$display("[pd_target_follow_drive] OK");
		else
			$display("[pd_target_follow_drive] ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/pfd_pkg.sv
src/pfd_pd_term.sv
src/pd_target_follow_drive.sv
tb/pd_follow_checker.sv
tb/tb_pd_target_follow_drive.sv
